>>> src/rwmp_pkg.sv
// Shared types and constants for the row-with-most-primes block.
package rwmp_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned MAG_W     = 31;
    localparam int unsigned SIZE_W    = 5;
    localparam int unsigned ROW_W     = 4;
    localparam int unsigned DVS_W     = 17;
    localparam int unsigned SQ_W      = 34;
    localparam int unsigned STEP_W    = 5;
    localparam int unsigned APB_AW    = 2;
    localparam int unsigned APB_DW    = 32;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;
    localparam logic [STEP_W-1:0] DIV_STEPS  = 5'd31;
    localparam logic [DVS_W-1:0]  FIRST_DVS  = 17'd2;
    localparam logic [DVS_W-1:0]  SECOND_DVS = 17'd3;
    localparam logic [SQ_W-1:0]   FIRST_SQ   = 34'd4;
    localparam logic [SQ_W-1:0]   SECOND_SQ  = 34'd9;
    localparam logic [MAG_W-1:0]  MIN_PRIME  = 31'd2;

    typedef enum logic [1:0] {
        PT_IDLE,
        PT_CHECK,
        PT_DIVIDE,
        PT_DONE
    } rwmp_pt_state_t;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_TEST,
        TOP_FINISH
    } rwmp_top_state_t;

    typedef struct packed {
        logic done;
        logic zero;
    } rwmp_rem_stat_t;

    typedef struct packed {
        logic done;
        logic prime;
    } rwmp_pt_stat_t;

endpackage

>>> src/row_with_most_primes.sv
// Top level: APB size register, request handshakes, per-row prime tally.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+---------------------------------
//   input    | s_valid / s_ready        | s_element_value (signed 32)
//   result   | m_valid / m_ready        | m_best_row (4)
//   config   | psel/penable/pwrite/...  | matrix_size at byte address 0
//
// Each element occupies the single remainder unit: 31 shift-subtract steps plus
// a compare per trial divisor, divisors 2 then odd ones. Negatives, 0 and 1
// finish without trial division; a prime near 2^31 needs about 23,200 divisors.
// s_ready is high only between elements.
// A result waits in the output register; a new request is taken meanwhile, and
// the tally stalls only if a second result finds that register still full.
// Synchronous active-low reset; size register resets to 16.
module row_with_most_primes #(
    parameter int unsigned MAX_SIZE = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rwmp_pkg::APB_AW-1:0]       paddr,
    input  logic [rwmp_pkg::APB_DW-1:0]       pwdata,
    output logic [rwmp_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [rwmp_pkg::DATA_W-1:0] s_element_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rwmp_pkg::ROW_W-1:0]        m_best_row
);

    localparam int unsigned POS_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_SIZE + 1);

    rwmp_pkg::rwmp_top_state_t     state_reg, state_next;
    logic [rwmp_pkg::SIZE_W-1:0]   size_reg;
    logic [CNT_W-1:0]              eff_size;
    logic [POS_W-1:0]              col_reg, col_next;
    logic [POS_W-1:0]              row_reg, row_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [CNT_W-1:0]              best_cnt_reg, best_cnt_next;
    logic [POS_W-1:0]              best_row_reg, best_row_next;
    logic                          have_best_reg, have_best_next;
    logic                          prime_reg;
    logic                          m_valid_reg, m_valid_next;
    logic [rwmp_pkg::ROW_W-1:0]    m_row_reg, m_row_next;
    logic                          cfg_write;
    logic                          pt_start;
    logic                          finish_go;
    logic                          col_last, row_last, take_new, emit;
    logic [CNT_W-1:0]              col_inc, row_inc, cnt_inc;
    rwmp_pkg::rwmp_pt_stat_t       pt_stat;

    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr == '0) ? rwmp_pkg::APB_DW'(size_reg) : '0;

    always_comb begin
        if (size_reg == '0) begin
            eff_size = CNT_W'(1);
        end else if (32'(size_reg) > MAX_SIZE) begin
            eff_size = CNT_W'(MAX_SIZE);
        end else begin
            eff_size = CNT_W'(size_reg);
        end
    end

    rwmp_prime_test u_test (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (pt_start),
        .value   (s_element_value),
        .stat    (pt_stat)
    );

    assign col_inc  = CNT_W'(col_reg) + CNT_W'(1);
    assign row_inc  = CNT_W'(row_reg) + CNT_W'(1);
    assign cnt_inc  = cnt_reg + CNT_W'(prime_reg);
    assign col_last = (col_inc == eff_size);
    assign row_last = (row_inc == eff_size);
    assign take_new = !have_best_reg || (cnt_inc > best_cnt_reg);
    assign emit     = col_last && row_last;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rwmp_pkg::TOP_IDLE: begin
                if (s_valid) begin
                    state_next = rwmp_pkg::TOP_TEST;
                end
            end
            rwmp_pkg::TOP_TEST: begin
                if (pt_stat.done) begin
                    state_next = rwmp_pkg::TOP_FINISH;
                end
            end
            rwmp_pkg::TOP_FINISH: begin
                if (finish_go) begin
                    state_next = rwmp_pkg::TOP_IDLE;
                end
            end
            default: state_next = rwmp_pkg::TOP_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = (state_reg == rwmp_pkg::TOP_IDLE);
        pt_start  = s_valid && (state_reg == rwmp_pkg::TOP_IDLE);
        finish_go = (state_reg == rwmp_pkg::TOP_FINISH) &&
                    !(emit && m_valid_reg && !m_ready);
    end

    always_comb begin
        col_next       = col_reg;
        row_next       = row_reg;
        cnt_next       = cnt_reg;
        best_cnt_next  = best_cnt_reg;
        best_row_next  = best_row_reg;
        have_best_next = have_best_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_row_next     = m_row_reg;
        if (cfg_write) begin
            col_next       = '0;
            row_next       = '0;
            cnt_next       = '0;
            best_cnt_next  = '0;
            best_row_next  = '0;
            have_best_next = 1'b0;
        end else if (finish_go) begin
            if (!col_last) begin
                col_next = POS_W'(col_inc);
                cnt_next = cnt_inc;
            end else if (!row_last) begin
                col_next = '0;
                row_next = POS_W'(row_inc);
                cnt_next = '0;
                if (take_new) begin
                    best_cnt_next  = cnt_inc;
                    best_row_next  = row_reg;
                    have_best_next = 1'b1;
                end
            end else begin
                // matrix done: report and start over
                m_valid_next   = 1'b1;
                m_row_next     = take_new ? rwmp_pkg::ROW_W'(row_reg)
                                          : rwmp_pkg::ROW_W'(best_row_reg);
                col_next       = '0;
                row_next       = '0;
                cnt_next       = '0;
                best_cnt_next  = '0;
                best_row_next  = '0;
                have_best_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rwmp_pkg::TOP_IDLE;
            size_reg      <= rwmp_pkg::SIZE_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            best_cnt_reg  <= '0;
            best_row_reg  <= '0;
            have_best_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            if (cfg_write) begin
                size_reg <= pwdata[rwmp_pkg::SIZE_W-1:0];
            end
            col_reg       <= col_next;
            row_reg       <= row_next;
            cnt_reg       <= cnt_next;
            best_cnt_reg  <= best_cnt_next;
            best_row_reg  <= best_row_next;
            have_best_reg <= have_best_next;
            m_valid_reg   <= m_valid_next;
        end
        m_row_reg <= m_row_next;
        if (pt_stat.done) begin
            prime_reg <= pt_stat.prime;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_best_row = m_row_reg;

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == rwmp_pkg::TOP_FINISH))
        else $error("result raised outside finish step");

    a_position_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (CNT_W'(col_reg) < eff_size) && (CNT_W'(row_reg) < eff_size))
        else $error("matrix position beyond size");

    a_test_done_when_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        pt_stat.done |-> (state_reg == rwmp_pkg::TOP_TEST))
        else $error("prime test finished while not awaited");

endmodule

>>> src/rwmp_rem_unit.sv
// Bit-serial remainder unit: one restoring shift-subtract step per cycle.
module rwmp_rem_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [rwmp_pkg::MAG_W-1:0]    dividend,
    input  logic [rwmp_pkg::DVS_W-1:0]    divisor,
    output rwmp_pkg::rwmp_rem_stat_t      stat
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [rwmp_pkg::STEP_W-1:0]   cnt_reg, cnt_next;
    logic [rwmp_pkg::DVS_W-1:0]    rem_reg, rem_next;
    logic [rwmp_pkg::MAG_W-1:0]    dvd_reg, dvd_next;
    logic [rwmp_pkg::DVS_W-1:0]    dvs_reg, dvs_next;
    logic [rwmp_pkg::DVS_W:0]      trial;
    logic [rwmp_pkg::DVS_W:0]      dvs_ext;
    logic                          fits;

    assign trial   = {rem_reg, dvd_reg[rwmp_pkg::MAG_W-1]};
    assign dvs_ext = {1'b0, dvs_reg};
    assign fits    = trial >= dvs_ext;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = rwmp_pkg::DIV_STEPS;
            rem_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? rwmp_pkg::DVS_W'(trial - dvs_ext) : trial[rwmp_pkg::DVS_W-1:0];
            dvd_next = {dvd_reg[rwmp_pkg::MAG_W-2:0], 1'b0};
            cnt_next = cnt_reg - rwmp_pkg::STEP_W'(1);
            if (cnt_reg == rwmp_pkg::STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign stat.done = done_reg;
    assign stat.zero = (rem_reg == '0);

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (rem_reg < dvs_reg))
        else $error("remainder not below divisor");

endmodule

>>> src/rwmp_prime_test.sv
// Trial-division sequencer driving its own remainder unit.
module rwmp_prime_test (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [rwmp_pkg::DATA_W-1:0]    value,
    output rwmp_pkg::rwmp_pt_stat_t        stat
);

    rwmp_pkg::rwmp_pt_state_t       state_reg, state_next;
    logic [rwmp_pkg::MAG_W-1:0]     value_reg, value_next;
    logic [rwmp_pkg::DVS_W-1:0]     dvs_reg, dvs_next;
    logic [rwmp_pkg::SQ_W-1:0]      sq_reg, sq_next;
    logic                           prime_reg, prime_next;
    logic                           rem_start;
    logic                           sq_over;
    logic                           trivial;
    rwmp_pkg::rwmp_rem_stat_t       rem_stat;

    assign sq_over = sq_reg > rwmp_pkg::SQ_W'(value_reg);
    assign trivial = value[rwmp_pkg::DATA_W-1] ||
                     (value[rwmp_pkg::MAG_W-1:0] < rwmp_pkg::MIN_PRIME);

    rwmp_rem_unit u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rem_start),
        .dividend (value_reg),
        .divisor  (dvs_reg),
        .stat     (rem_stat)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rwmp_pkg::PT_IDLE: begin
                if (start) begin
                    state_next = trivial ? rwmp_pkg::PT_DONE : rwmp_pkg::PT_CHECK;
                end
            end
            rwmp_pkg::PT_CHECK: begin
                state_next = sq_over ? rwmp_pkg::PT_DONE : rwmp_pkg::PT_DIVIDE;
            end
            rwmp_pkg::PT_DIVIDE: begin
                if (rem_stat.done) begin
                    state_next = rem_stat.zero ? rwmp_pkg::PT_DONE : rwmp_pkg::PT_CHECK;
                end
            end
            rwmp_pkg::PT_DONE: begin
                state_next = rwmp_pkg::PT_IDLE;
            end
            default: state_next = rwmp_pkg::PT_IDLE;
        endcase
    end

    always_comb begin
        rem_start  = (state_reg == rwmp_pkg::PT_CHECK) && !sq_over;
        stat.done  = (state_reg == rwmp_pkg::PT_DONE);
        stat.prime = prime_reg;
    end

    always_comb begin
        value_next = value_reg;
        dvs_next   = dvs_reg;
        sq_next    = sq_reg;
        prime_next = prime_reg;
        unique case (state_reg)
            rwmp_pkg::PT_IDLE: begin
                if (start) begin
                    value_next = value[rwmp_pkg::MAG_W-1:0];
                    dvs_next   = rwmp_pkg::FIRST_DVS;
                    sq_next    = rwmp_pkg::FIRST_SQ;
                    prime_next = 1'b0;
                end
            end
            rwmp_pkg::PT_CHECK: begin
                if (sq_over) begin
                    prime_next = 1'b1;
                end
            end
            rwmp_pkg::PT_DIVIDE: begin
                if (rem_stat.done && !rem_stat.zero) begin
                    // after 2, odd divisors only; (d+2)^2 = d^2 + 4d + 4
                    if (dvs_reg == rwmp_pkg::FIRST_DVS) begin
                        dvs_next = rwmp_pkg::SECOND_DVS;
                        sq_next  = rwmp_pkg::SECOND_SQ;
                    end else begin
                        dvs_next = dvs_reg + rwmp_pkg::DVS_W'(2);
                        sq_next  = sq_reg + rwmp_pkg::SQ_W'({dvs_reg, 2'b00})
                                   + rwmp_pkg::SQ_W'(4);
                    end
                end
            end
            rwmp_pkg::PT_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rwmp_pkg::PT_IDLE;
            prime_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            prime_reg <= prime_next;
        end
        value_reg <= value_next;
        dvs_reg   <= dvs_next;
        sq_reg    <= sq_next;
    end

    a_square_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rwmp_pkg::PT_CHECK || state_reg == rwmp_pkg::PT_DIVIDE)
        |-> (sq_reg == rwmp_pkg::SQ_W'(dvs_reg * dvs_reg)))
        else $error("divisor square out of step");

endmodule

>>> bench/row_with_most_primes_tb.sv
// Self-checking testbench for the row-with-most-primes block: scoreboard, drivers, watchdog.
module row_with_most_primes_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_ROWS         = 16;
    localparam logic [rwmp_pkg::APB_AW-1:0] MATRIX_SIZE_ADDR = '0;
    localparam int unsigned SETTLE_CYCLES    = 3000;
    localparam int unsigned HOLD_CYCLES      = 3000;
    localparam int unsigned STALL_LIMIT      = 4000000;
    localparam int unsigned PARTIAL_ITEMS    = 20;
    localparam int unsigned STEADY_ITEMS     = 24;
    localparam int unsigned RANDOM_ITEMS     = 48;

    class prime_row_tally;
        logic [rwmp_pkg::SIZE_W-1:0] size_reg;
        logic [rwmp_pkg::SIZE_W-1:0] col;
        logic [rwmp_pkg::SIZE_W-1:0] row;
        logic [rwmp_pkg::SIZE_W-1:0] row_primes;
        logic [rwmp_pkg::SIZE_W-1:0] best_primes;
        logic [rwmp_pkg::SIZE_W-1:0] best_row;
        bit                          have_best;
        logic [rwmp_pkg::ROW_W-1:0]  pending_rows[$];
        int unsigned                 mismatches;

        function new();
            size_reg   = rwmp_pkg::SIZE_RESET;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            col         = '0;
            row         = '0;
            row_primes  = '0;
            best_primes = '0;
            best_row    = '0;
            have_best   = 1'b0;
        endfunction

        function void write_size(logic [rwmp_pkg::APB_DW-1:0] data);
            size_reg = data[rwmp_pkg::SIZE_W-1:0];
            restart();
        endfunction

        function int unsigned rows_in_use();
            if (size_reg == 0) return 1;
            if (size_reg > MAX_ROWS) return MAX_ROWS;
            return 32'(size_reg);
        endfunction

        function bit is_prime(logic [rwmp_pkg::DATA_W-1:0] bits);
            longint unsigned v;
            v = 64'(bits);
            if (bits[rwmp_pkg::DATA_W-1] || v < 2) return 1'b0;
            for (longint unsigned d = 2; d * d <= v; d++)
                if (v % d == 0) return 1'b0;
            return 1'b1;
        endfunction

        function void note_element(logic [rwmp_pkg::DATA_W-1:0] bits);
            int unsigned n;
            n = rows_in_use();
            if (col >= n || row >= n) begin
                col = '0;
                row = '0;
            end
            if (is_prime(bits)) row_primes++;
            col++;
            if (col < n) return;
            col = '0;
            // first finished row always wins; ties keep the earlier row
            if (!have_best || row_primes > best_primes) begin
                best_primes = row_primes;
                best_row    = row;
                have_best   = 1'b1;
            end
            row_primes = '0;
            row++;
            if (row < n) return;
            pending_rows.push_back(best_row[rwmp_pkg::ROW_W-1:0]);
            restart();
        endfunction

        function void check_best_row(logic [rwmp_pkg::ROW_W-1:0] got);
            logic [rwmp_pkg::ROW_W-1:0] want;
            if (pending_rows.size() == 0) begin
                $display("%0t: best_row %0d arrived with no matrix finished", $time, got);
                mismatches++;
                return;
            end
            want = pending_rows.pop_front();
            if (got !== want) begin
                $display("%0t: best_row mismatch, expected %0d, actual %0d", $time, want, got);
                mismatches++;
            end
        endfunction
    endclass

    logic                                aclk;
    logic                                aresetn;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [rwmp_pkg::APB_AW-1:0]         paddr;
    logic [rwmp_pkg::APB_DW-1:0]         pwdata;
    logic [rwmp_pkg::APB_DW-1:0]         prdata;
    logic                                pready;
    logic                                s_valid;
    logic                                s_ready;
    logic signed [rwmp_pkg::DATA_W-1:0]  s_element_value;
    logic                                m_valid;
    logic                                m_ready;
    logic [rwmp_pkg::ROW_W-1:0]          m_best_row;

    prime_row_tally tally = new();
    bit             steady = 1'b0;
    bit             stall_results = 1'b0;
    int unsigned    quiet_cycles = 0;

    row_with_most_primes #(.MAX_SIZE(MAX_ROWS)) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_element_value (s_element_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_best_row      (m_best_row)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) tally.note_element(s_element_value);
        if (aresetn && m_valid && m_ready) tally.check_best_row(m_best_row);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: random back-pressure, or a long hold when asked
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_results) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                stall_results = 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= 23);
            end
        end
    end

    task automatic write_matrix_size(input logic [rwmp_pkg::APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MATRIX_SIZE_ADDR;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        tally.write_size(data);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // leaves s_valid high on return; the next request or finish_phase decides
    task automatic send_element(input logic [rwmp_pkg::DATA_W-1:0] value);
        while (!steady && $urandom_range(99) < 23) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_element_value <= value;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        do @(negedge aclk); while (tally.pending_rows.size() != 0);
    endtask

    task automatic finish_phase();
        s_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [rwmp_pkg::DATA_W-1:0] cheap_element();
        if ($urandom_range(99) < 70) return $urandom_range(200);
        return $urandom | 32'h8000_0000;
    endfunction

    function automatic logic [rwmp_pkg::DATA_W-1:0] random_element();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40) return $urandom_range(200);
        if (pick < 60) return $urandom_range(20000);
        if (pick < 75) return $urandom | 32'h8000_0000;
        if (pick < 90) return $urandom & 32'h7FFF_FFFE;
        case ($urandom_range(5))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'h0000_0002;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h8000_0000;
            default: return 32'h0000_0003;
        endcase
    endfunction

    initial begin
        int unsigned                 random_items;
        int unsigned                 n;
        int unsigned                 r;
        logic [rwmp_pkg::SIZE_W-1:0] pick_size;

        aresetn         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        s_valid         = 1'b0;
        s_element_value = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // size register at its reset value: part of a matrix, no result yet
        repeat (PARTIAL_ITEMS) send_element(cheap_element());
        finish_phase();

        // one element per matrix: field extremes, largest prime first
        write_matrix_size(1);
        send_element(32'h7FFF_FFFF);
        send_element(32'h8000_0000);
        send_element(32'h0000_0000);
        send_element(32'h0000_0001);
        send_element(32'h0000_0002);
        send_element(32'h0000_0004);
        finish_phase();

        // zero size acts as one
        write_matrix_size(0);
        send_element(32'h0000_0003);
        finish_phase();

        // abandoned matrix, then prime-free, tie and later-better matrices
        write_matrix_size(2);
        send_element(32'h0000_0002);
        send_element(32'h0000_0003);
        send_element(32'h0000_0005);
        finish_phase();
        write_matrix_size(2);
        send_element(32'h0000_0000);
        send_element(32'h0000_0001);
        send_element(32'h0000_0004);
        send_element(32'hFFFF_FFFF);
        send_element(32'h0000_0002);
        send_element(32'h0000_0003);
        send_element(32'h0000_0005);
        send_element(32'h0000_0007);
        send_element(32'h0000_0004);
        send_element(32'h7FFF_FFFE);
        send_element(32'h0000_0007);
        send_element(32'h0000_000B);
        finish_phase();

        // oversized write saturates; no idling on either side here
        write_matrix_size(32'hFFFF_FFFF);
        steady = 1'b1;
        repeat (STEADY_ITEMS) send_element(cheap_element());
        finish_phase();
        steady = 1'b0;

        // hold results off so the output register fills and requests back up
        write_matrix_size(1);
        stall_results = 1'b1;
        repeat (8) send_element($urandom_range(200));
        finish_phase();

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            r = $urandom_range(99);
            if (r < 60)
                pick_size = rwmp_pkg::SIZE_W'($urandom_range(2));
            else if (r < 90)
                pick_size = 3;
            else
                pick_size = rwmp_pkg::SIZE_W'($urandom_range(6, 4));
            n = (pick_size == 0) ? 1 : 32'(pick_size);
            write_matrix_size(32'(pick_size));
            repeat ($urandom_range(4, 1)) begin
                repeat (n * n) begin
                    send_element(random_element());
                    random_items++;
                    if (random_items == RANDOM_ITEMS / 2) begin
                        s_valid <= 1'b0;
                        wait_drained();
                    end
                end
            end
            if (n > 1 && $urandom_range(3) == 0)
                repeat ($urandom_range(n * n - 1, 1)) send_element($urandom_range(200));
            finish_phase();
        end

        if (tally.mismatches == 0 && tally.pending_rows.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
src/rwmp_pkg.sv
src/rwmp_rem_unit.sv
src/rwmp_prime_test.sv
src/row_with_most_primes.sv
bench/row_with_most_primes_tb.sv
